### rtl/assert_macros.svh
// Assertion macros used by the checker file rvc_checker.sv.
// Depends on nothing; each macro clocks on a rising edge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds too.
`define RVC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define RVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rvc_pkg.sv
// Types and constants of the radial vignetting correction block.
// Used by every module of the block but rvc_ram; depends on nothing.
package rvc_pkg;

	// item opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_SCALE_RATIO,
		CFG_PROFILE_LENGTH
	} cfg_idx_t;

	localparam int CFG_W   = 17;  // widest register
	localparam int D8_W    = 21;  // scaled distance, Q.8
	localparam int SQ_W    = 42;  // squared distance
	localparam int SUM_W   = 43;  // sum of squares
	localparam int ROOT_W  = 22;  // radius, Q.8
	localparam int V_W     = 25;  // blended factor, Q.23
	localparam int NUM_W   = 33;  // divider remainder
	localparam int QBITS   = 8;   // quotient bits

	typedef logic [2:0][7:0] chan3_t;  // [2] blue, [1] green, [0] red

	// how the factor is taken from the profile
	typedef enum logic [1:0] {
		V_ZERO,
		V_BLEND,
		V_LAST
	} vsel_t;

	typedef struct packed {
		logic        op;
		logic [11:0] col;
		logic [11:0] row;
		logic [6:0]  entry_index;
		logic [15:0] entry_value;
		logic [7:0]  blue_in;
		logic [7:0]  green_in;
		logic [7:0]  red_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] blue_out;
		logic [7:0] green_out;
		logic [7:0] red_out;
	} out_word_t;

	// fields that ride along the radius pipeline
	typedef struct packed {
		logic        op;
		logic [6:0]  entry_index;
		logic [15:0] entry_value;
		chan3_t      pix;
	} side_t;

endpackage

### rtl/rvc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rvc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/rvc_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on rvc_pkg.
module rvc_sqrt import rvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  in_x,
	input  side_t             in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output side_t             out_side
);
	localparam int X_W   = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic              v_q    [ROOT_W];
	logic [X_W-1:0]    x_q    [ROOT_W];
	logic [REM_W-1:0]  rem_q  [ROOT_W];
	logic [ROOT_W-1:0] root_q [ROOT_W];
	side_t             side_q [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_st
		logic              pv;
		logic [X_W-1:0]    px;
		logic [REM_W-1:0]  prem;
		logic [ROOT_W-1:0] proot;
		side_t             pside;
		logic [REM_W+1:0]  rem_n;
		logic [REM_W-1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign px    = X_W'(in_x);
			assign prem  = '0;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_q[k-1];
			assign px    = x_q[k-1];
			assign prem  = rem_q[k-1];
			assign proot = root_q[k-1];
			assign pside = side_q[k-1];
		end

		// bring down two bits and try the next root bit
		always_comb begin
			rem_n = {prem, px[X_W-1 -: 2]};
			trial = {proot, 2'b01};
			take  = rem_n >= (REM_W+2)'(trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k]    <= px << 2;
				rem_q[k]  <= take ? REM_W'(rem_n - (REM_W+2)'(trial)) : REM_W'(rem_n);
				root_q[k] <= {proot[ROOT_W-2:0], take};
				side_q[k] <= pside;
			end
		end
	end

	assign out_valid = v_q[ROOT_W-1];
	assign out_root  = root_q[ROOT_W-1];
	assign out_side  = side_q[ROOT_W-1];
endmodule

### rtl/rvc_div.sv
// Pipelined saturating divider: three channels of (pix << 23) / v, one quotient bit a stage.
// Depends on rvc_pkg.
module rvc_div import rvc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [V_W-1:0] in_v,
	input  chan3_t         in_pix,
	output logic           out_valid,
	output chan3_t         out_pix
);
	logic                      v_q   [QBITS];
	logic [V_W-1:0]            d_q   [QBITS];
	logic [2:0][NUM_W-1:0]     rem_q [QBITS];
	chan3_t                    quo_q [QBITS];
	logic [2:0]                sat_q [QBITS];
	logic                      vz_q  [QBITS];

	for (genvar k = 0; k < QBITS; k++) begin : g_st
		logic                  pv;
		logic [V_W-1:0]        pd;
		logic [2:0][NUM_W-1:0] prem;
		chan3_t                pquo;
		logic [2:0]            psat;
		logic                  pvz;
		logic [NUM_W-1:0]      dsh;
		logic [2:0]            take;

		if (k == 0) begin : g_first
			// start from the full numerator and flag saturating channels
			always_comb begin
				pv   = in_valid;
				pd   = in_v;
				pvz  = in_v == '0;
				pquo = '0;
				for (int c = 0; c < 3; c++) begin
					prem[c] = {2'b00, in_pix[c], 23'd0};
					psat[c] = pvz ? (in_pix[c] != 8'd0)
						: ({2'b00, in_pix[c], 15'd0} >= in_v);
				end
			end
		end else begin : g_next
			always_comb begin
				pv   = v_q[k-1];
				pd   = d_q[k-1];
				pvz  = vz_q[k-1];
				pquo = quo_q[k-1];
				prem = rem_q[k-1];
				psat = sat_q[k-1];
			end
		end

		// compare against the divisor shifted to this bit
		always_comb begin
			dsh = NUM_W'(pd) << (QBITS - 1 - k);
			for (int c = 0; c < 3; c++) begin
				take[c] = prem[c] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_q[k]   <= pd;
				vz_q[k]  <= pvz;
				sat_q[k] <= psat;
				for (int c = 0; c < 3; c++) begin
					rem_q[k][c] <= take[c] ? prem[c] - dsh : prem[c];
					quo_q[k][c] <= pquo[c] | (8'(take[c]) << (QBITS - 1 - k));
				end
			end
		end
	end

	// apply saturation and the zero-divisor rule
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (sat_q[QBITS-1][c]) begin
				out_pix[c] = 8'hFF;
			end else if (vz_q[QBITS-1]) begin
				out_pix[c] = 8'h00;
			end else begin
				out_pix[c] = quo_q[QBITS-1][c];
			end
		end
	end

	assign out_valid = v_q[QBITS-1];
endmodule

### rtl/radial_vignetting_correction.sv
// Radial vignetting correction: offset and scaling, square root, profile
// lookup and blend, and a per-channel divide. Uses rvc_pkg, rvc_sqrt, rvc_div, rvc_ram.
//
// Use: items enter on in_valid/in_ready with payload in_data. A load item
// (op = OP_LOAD) writes one profile entry and gives no result; a pixel item
// gives one corrected word on out_valid/out_ready/out_data. Results leave in
// input order.
// Stages: 4 distance stages, 22 square-root stages, lookup and blend, 8 divider
// stages, output buffer. Throughput: one item per cycle while in_ready is high;
// every stage holds one item and all advance together. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Reset clears the
// pipeline and sets the registers to their defaults; the profile memory holds
// no reset value and must be loaded before use. When the receiver stalls, a
// two-word output buffer keeps taking results; only when both words are full
// does in_ready drop and the pipeline hold.
module radial_vignetting_correction import rvc_pkg::*; #(
	parameter int TABLE_DEPTH = 128,
	parameter int COORD_BITS  = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int LEN_W = $clog2(TABLE_DEPTH + 1);
	localparam int CB    = (COORD_BITS < 12) ? COORD_BITS : 12;
	localparam logic [11:0] COORD_MASK = 12'((32'd1 << CB) - 1);
	localparam logic [1:0] BUF_FULL = 2'd2;

	// configuration registers
	logic [15:0] center_x_q, center_y_q;
	logic [16:0] scale_ratio_q;
	logic [7:0]  profile_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q       <= '0;
			center_y_q       <= '0;
			scale_ratio_q    <= 17'h10000;
			profile_length_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:       center_x_q       <= cfg_data[15:0];
				CFG_CENTER_Y:       center_y_q       <= cfg_data[15:0];
				CFG_SCALE_RATIO:    scale_ratio_q    <= cfg_data;
				CFG_PROFILE_LENGTH: profile_length_q <= cfg_data[7:0];
			endcase
		end
	end

	logic en;
	assign in_ready = en;

	// stage 1: distance magnitudes
	logic        v_s1;
	side_t       side_s1;
	logic [15:0] magx_s1, magy_s1;
	logic [15:0] posx, posy;
	side_t       side_in;

	always_comb begin
		posx = {in_data.col & COORD_MASK, 4'd0};
		posy = {in_data.row & COORD_MASK, 4'd0};
		side_in.op          = in_data.op;
		side_in.entry_index = in_data.entry_index;
		side_in.entry_value = in_data.entry_value;
		side_in.pix         = {in_data.blue_in, in_data.green_in, in_data.red_in};
	end

	// stages 2 to 4: scale, square, sum
	logic              v_s2, v_s3, v_s4;
	side_t             side_s2, side_s3, side_s4;
	logic [D8_W-1:0]   dx_s2, dy_s2;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [SUM_W-1:0]  sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			magx_s1 <= (posx >= center_x_q) ? posx - center_x_q : center_x_q - posx;
			magy_s1 <= (posy >= center_y_q) ? posy - center_y_q : center_y_q - posy;
			side_s2 <= side_s1;
			dx_s2   <= D8_W'((33'(magx_s1) * 33'(scale_ratio_q)) >> 12);
			dy_s2   <= D8_W'((33'(magy_s1) * 33'(scale_ratio_q)) >> 12);
			side_s3 <= side_s2;
			sqx_s3  <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
			sqy_s3  <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
			side_s4 <= side_s3;
			sum_s4  <= SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
		end
	end

	// radius
	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	rvc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_x      (sum_s4),
		.in_side   (side_s4),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// stage 5: pick profile entries
	logic [ROOT_W-9:0] nr;
	logic [LEN_W-1:0]  len;
	vsel_t             mode;
	logic [AW-1:0]     addra, addrb;

	always_comb begin
		nr = sq_root[ROOT_W-1:8];
		if (profile_length_q == 8'd0) begin
			len = LEN_W'(1);
		end else if (32'(profile_length_q) > TABLE_DEPTH) begin
			len = LEN_W'(TABLE_DEPTH);
		end else begin
			len = LEN_W'(profile_length_q);
		end
		addrb = AW'(nr);
		priority if (nr == '0) begin
			mode  = V_ZERO;
			addra = '0;
		end else if (32'(nr) < 32'(len)) begin
			mode  = V_BLEND;
			addra = AW'(nr - 1'b1);
		end else begin
			mode  = V_LAST;
			addra = AW'(len - 1'b1);
		end
	end

	logic          v_s5;
	side_t         side_s5;
	logic [7:0]    fr_s5;
	vsel_t         mode_s5;
	logic [AW-1:0] addra_s5, addrb_s5;

	// stage 6: entries read, form the factor
	logic          v_s6;
	chan3_t        pix_s6;
	logic [7:0]    fr_s6;
	vsel_t         mode_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= sq_v;
			v_s6 <= v_s5 && (side_s5.op == OP_PIXEL);  // drop load words here
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5  <= sq_side;
			fr_s5    <= sq_root[7:0];
			mode_s5  <= mode;
			addra_s5 <= addra;
			addrb_s5 <= addrb;
			pix_s6   <= side_s5.pix;
			fr_s6    <= fr_s5;
			mode_s6  <= mode_s5;
		end
	end

	// two copies of the profile so both neighbours are read in the same cycle
	logic          ram_we, ram_re;
	logic [15:0]   ent_a, ent_b;

	assign ram_we = en && v_s5 && (side_s5.op == OP_LOAD)
		&& (32'(side_s5.entry_index) < TABLE_DEPTH);
	assign ram_re = en && v_s5 && (side_s5.op == OP_PIXEL);

	rvc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(side_s5.entry_index)),
		.wdata (side_s5.entry_value),
		.re    (ram_re),
		.raddr (addra_s5),
		.rdata (ent_a)
	);

	rvc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(side_s5.entry_index)),
		.wdata (side_s5.entry_value),
		.re    (ram_re),
		.raddr (addrb_s5),
		.rdata (ent_b)
	);

	logic [V_W-1:0] vfac;

	always_comb begin
		unique case (mode_s6)
			V_BLEND: vfac = V_W'(ent_a) * V_W'(9'd256 - 9'(fr_s6))
				+ V_W'(ent_b) * V_W'(fr_s6);
			V_ZERO,
			V_LAST:  vfac = V_W'(ent_a) << 8;
			default: vfac = V_W'(ent_a) << 8;
		endcase
	end

	// divide each channel
	logic   dv_v;
	chan3_t dv_pix;

	rvc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_v      (vfac),
		.in_pix    (pix_s6),
		.out_valid (dv_v),
		.out_pix   (dv_pix)
	);

	// two-word output buffer
	out_word_t  buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign en   = cnt_q != BUF_FULL;
	assign push = en && dv_v;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= out_word_t'(dv_pix);
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_data  = buf_q[rd_ptr_q];
endmodule

### rtl/rvc_checker.sv
// Port-level checks of the radial vignetting correction block, bound to the top level.
// Depends on rvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rvc_checker import rvc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);
	logic unused_in;
	assign unused_in = in_valid ^ (^in_data);

	// a held result word stays offered and unchanged
	`RVC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result word dropped")
	`RVC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data), "result word changed")
	// input stalls only behind a waiting result
	`RVC_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid, "stall with no result waiting")
	// a full buffer with no word taken stays full
	`RVC_ASSERT_NEXT(a_full_holds, clk, arst_n, !in_ready && !out_ready, !in_ready, "buffer drained without a take")
endmodule

bind radial_vignetting_correction rvc_checker u_rvc_checker (.*);

### dv/rvc_scoreboard.sv
// Shading predictor and result checker for the radial vignetting correction block.
// Depends on rvc_pkg; watches the input, output and register ports beside the block.
module rvc_scoreboard import rvc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_word_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_word_t        out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               pending,
	output int               fail_count
);

	localparam int DEPTH = 128;

	// predictor state: registers and shading profile
	logic [15:0] ctr_x, ctr_y;
	logic [16:0] ratio;
	logic [7:0]  plen;
	logic [15:0] shading [DEPTH];
	out_word_t   expected_pixels [$];

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root, trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic longint unsigned scaled_offset(logic [11:0] coord, logic [15:0] ctr);
		longint unsigned pos, mag;
		pos = {coord, 4'd0};
		mag = (pos >= ctr) ? pos - ctr : ctr - pos;
		return (mag * ratio) >> 12;
	endfunction

	function automatic logic [7:0] divide_channel(logic [7:0] pix, longint unsigned v);
		longint unsigned q;
		if (v == 0)
			return (pix != 0) ? 8'd255 : 8'd0;
		q = ({56'd0, pix} << 23) / v;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic out_word_t correct_pixel(in_word_t w);
		longint unsigned dx, dy, rad, ring, frac, v, len;
		out_word_t o;
		len = (plen == 0) ? 1 : ((plen > DEPTH) ? DEPTH : plen);
		dx = scaled_offset(w.col, ctr_x);
		dy = scaled_offset(w.row, ctr_y);
		rad = int_sqrt(dx * dx + dy * dy);
		ring = rad >> 8;
		frac = rad & 255;
		if (ring == 0)
			v = longint'(shading[0]) << 8;
		else if (ring < len)
			v = shading[ring - 1] * (256 - frac) + shading[ring] * frac;
		else
			v = longint'(shading[len - 1]) << 8;
		o.blue_out  = divide_channel(w.blue_in, v);
		o.green_out = divide_channel(w.green_in, v);
		o.red_out   = divide_channel(w.red_in, v);
		return o;
	endfunction

	// track registers, predict accepted words, compare delivered words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x = 0;
			ctr_y = 0;
			ratio = 17'd65536;
			plen = 8'd1;
			expected_pixels.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CENTER_X:       ctr_x = cfg_data[15:0];
					CFG_CENTER_Y:       ctr_y = cfg_data[15:0];
					CFG_SCALE_RATIO:    ratio = cfg_data;
					CFG_PROFILE_LENGTH: plen = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected output word %h", out_data);
					fail_count++;
				end else begin
					out_word_t e;
					e = expected_pixels.pop_front();
					if (e.blue_out !== out_data.blue_out) begin
						$error("blue_out expected %0d got %0d", e.blue_out, out_data.blue_out);
						fail_count++;
					end
					if (e.green_out !== out_data.green_out) begin
						$error("green_out expected %0d got %0d", e.green_out, out_data.green_out);
						fail_count++;
					end
					if (e.red_out !== out_data.red_out) begin
						$error("red_out expected %0d got %0d", e.red_out, out_data.red_out);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.op == OP_LOAD)
					shading[in_data.entry_index] = in_data.entry_value;
				else
					expected_pixels.push_back(correct_pixel(in_data));
			end
		end
		pending = expected_pixels.size();
	end

endmodule

### dv/tb_radial_vignetting_correction.sv
// Top of the radial vignetting correction testbench: clock, reset, stimulus and verdict.
// Depends on rvc_pkg, the block and rvc_scoreboard, which checks every delivered word.
module tb_radial_vignetting_correction import rvc_pkg::*;;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_word_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_word_t        out_data;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	int               pending, fail_count;
	int               tx_gap_max = 15;
	int               rx_stall_max = 15;
	logic [15:0]      cur_cx, cur_cy;

	always #10 clk = ~clk;

	radial_vignetting_correction dut (.*);

	rvc_scoreboard checker_i (.*);

	// hold the run to a fixed ceiling
	initial begin
		#(20 * 600000);
		$display("radial_vignetting_correction test failed");
		$finish;
	end

	// stall the receiver a random number of cycles before each word
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, rx_stall_max);
			if (n != 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	task automatic send_word(in_word_t w);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	function automatic in_word_t load_word(logic [6:0] idx, logic [15:0] val);
		in_word_t w;
		w = in_word_t'(72'({$urandom, $urandom, $urandom}));
		w.op = OP_LOAD;
		w.entry_index = idx;
		w.entry_value = val;
		return w;
	endfunction

	function automatic in_word_t pixel_word(logic [11:0] c, logic [11:0] r,
			logic [7:0] b, logic [7:0] g, logic [7:0] rd);
		in_word_t w;
		w = in_word_t'(72'({$urandom, $urandom, $urandom}));
		w.op = OP_PIXEL;
		w.col = c;
		w.row = r;
		w.blue_in = b;
		w.green_in = g;
		w.red_in = rd;
		return w;
	endfunction

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// anywhere half the time, else near the optical centre
	function automatic logic [11:0] rand_coord(logic [15:0] ctr);
		if ($urandom_range(0, 1))
			return 12'($urandom_range(0, 4095));
		return 12'((ctr >> 4) + $urandom_range(0, 600) - 300);
	endfunction

	// wait out every result and the pipeline depth before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] cx, logic [15:0] cy, logic [16:0] sr, logic [7:0] len);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CENTER_X;
		cfg_data <= {1'($urandom_range(0, 1)), cx};
		@(posedge clk);
		cfg_index <= CFG_CENTER_Y;
		cfg_data <= {1'($urandom_range(0, 1)), cy};
		@(posedge clk);
		cfg_index <= CFG_SCALE_RATIO;
		cfg_data <= sr;
		@(posedge clk);
		cfg_index <= CFG_PROFILE_LENGTH;
		cfg_data <= {9'($urandom_range(0, 511)), len};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cx = cx;
		cur_cy = cy;
	endtask

	task automatic random_words(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 15)
				send_word(load_word(7'($urandom_range(0, 127)),
					($urandom_range(0, 30) == 0) ? 16'd0 : 16'($urandom)));
			else
				send_word(pixel_word(rand_coord(cur_cx), rand_coord(cur_cy),
					rand_chan(), rand_chan(), rand_chan()));
		end
	endtask

	initial begin
		logic [16:0] sr;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_cx = 0;
		cur_cy = 0;

		// fill the whole profile so no unwritten entry is ever read
		for (int i = 0; i < 128; i++)
			send_word(load_word(7'(i),
				(i == 0) ? 16'd32768 : 16'($urandom_range(1, 65535))));

		// directed: reset registers, corners, centre, zero and full channels
		send_word(pixel_word(0, 0, 8'd255, 8'd0, 8'd128));
		send_word(pixel_word(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255));
		send_word(pixel_word(12'd4095, 0, 8'd1, 8'd254, 8'd0));
		send_word(load_word(0, 16'd1));
		send_word(pixel_word(0, 0, 8'd255, 8'd1, 8'd0));
		// zero divisor
		send_word(load_word(0, 16'd0));
		send_word(pixel_word(0, 0, 8'd0, 8'd7, 8'd255));
		// factor above one darkens
		send_word(load_word(0, 16'hFFFF));
		send_word(pixel_word(0, 0, 8'd255, 8'd100, 8'd1));
		send_word(load_word(0, 16'd32768));
		drain();

		// blend inside the table with the longest profile
		set_regs(16'd32768, 16'd32768, 17'd4096, 8'd128);
		send_word(pixel_word(12'd2048, 12'd2048, 8'd200, 8'd100, 8'd50));
		send_word(pixel_word(12'd2049, 12'd2048, 8'd200, 8'd100, 8'd50));
		send_word(pixel_word(12'd2100, 12'd2070, 8'd255, 8'd255, 8'd255));
		send_word(pixel_word(12'd2400, 12'd2500, 8'd90, 8'd180, 8'd30));
		send_word(pixel_word(0, 12'd4095, 8'd255, 8'd0, 8'd255));
		drain();

		// out-of-range length and ratio extremes
		set_regs(16'hFFFF, 16'hFFFF, 17'h1FFFF, 8'd0);
		send_word(pixel_word(0, 0, 8'd255, 8'd10, 8'd20));
		send_word(pixel_word(12'd4095, 12'd4095, 8'd3, 8'd10, 8'd20));
		drain();
		set_regs(16'd1000, 16'd0, 17'd0, 8'd255);
		send_word(pixel_word(12'd4095, 12'd4095, 8'd255, 8'd77, 8'd20));
		send_word(pixel_word(12'd17, 12'd300, 8'd255, 8'd77, 8'd20));
		drain();

		// random phases, the first three at the register extremes, the fourth at set values
		for (int ph = 0; ph < 10; ph++) begin
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			case (ph)
				0: set_regs(16'd0, 16'd0, 17'd65536, 8'd1);
				1: set_regs(16'hFFFF, 16'd0, 17'd1, 8'd128);
				2: set_regs(16'd32768, 16'd32768, 17'h1FFFF, 8'd255);
				3: set_regs(16'd20000, 16'd45000, 17'd2500, 8'd128);
				default: begin
					sr = 17'($urandom_range(0, (1 << $urandom_range(0, 17)) - 1));
					set_regs(16'($urandom), 16'($urandom), sr, 8'($urandom_range(0, 255)));
				end
			endcase
			random_words(200);
			drain();
		end

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("radial_vignetting_correction test passed");
		else
			$display("radial_vignetting_correction test failed");
		$finish;
	end

endmodule
